// ===== hw/rtl/pid_pkg.sv =====
// ---------------------------------------------------------------------------
// pid_pkg: shared types and constants for the priority interrupt dispatcher
// Request kinds, fixed field widths, reset defaults and the control bundle
// that the sequencer hands to the row of source cells.
// ---------------------------------------------------------------------------
package pid_pkg;

  localparam int NUM_SOURCES_DEF   = 32;
  localparam int PRIORITY_BITS_DEF = 8;

  // fixed field widths of the stream payload
  localparam int KIND_W   = 2;
  localparam int SRC_W    = 5;
  localparam int PRIO_IN_W = 8;
  localparam int MASK_W   = 32;
  localparam int PRIO_MAX_W = 16;

  localparam logic [PRIO_IN_W-1:0] DEFAULT_PRIO_RESET = 8'd128;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ATTACH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DETACH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET_PRIO = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd3;

  typedef struct packed {
    logic              table_wr;  // table request accepted this cycle
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  source;
    logic              load;      // copy table into sort slots
    logic              sort;      // odd-even compare-exchange step
    logic              phase;     // which pairs exchange this step
    logic              shift;     // head taken, move slots toward cell 0
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/pid_cell.sv =====
// ---------------------------------------------------------------------------
// pid_cell: one interrupt source cell
// Holds the source's priority and attached flag plus one sort slot that
// exchanges with its neighbors during a dispatch and shifts out toward cell 0.
// ---------------------------------------------------------------------------
module pid_cell #(
  parameter int NUM_SOURCES   = pid_pkg::NUM_SOURCES_DEF,
  parameter int PRIORITY_BITS = pid_pkg::PRIORITY_BITS_DEF,
  parameter int IDX           = 0,
  parameter int IDX_W         = $clog2(NUM_SOURCES)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pid_pkg::cell_ctrl_t      ctrl,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [PRIORITY_BITS-1:0] dflt_prio,
  input  logic                     pend,
  // left neighbor slot
  input  logic                     left_valid,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [IDX_W-1:0]         left_idx,
  input  logic                     left_att,
  // right neighbor slot
  input  logic                     right_valid,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [IDX_W-1:0]         right_idx,
  input  logic                     right_att,
  // own slot
  output logic                     slot_valid,
  output logic [PRIORITY_BITS-1:0] slot_prio,
  output logic [IDX_W-1:0]         slot_idx,
  output logic                     slot_att
);

  localparam logic [pid_pkg::PRIO_MAX_W-1:0] RST_WIDE =
    pid_pkg::PRIO_MAX_W'(pid_pkg::DEFAULT_PRIO_RESET);
  localparam logic [PRIORITY_BITS-1:0] RST_PRIO = RST_WIDE[PRIORITY_BITS-1:0];
  localparam logic ODD       = (IDX % 2) == 1;
  localparam logic HAS_LEFT  = IDX > 0;
  localparam logic HAS_RIGHT = IDX < NUM_SOURCES - 1;

  logic [PRIORITY_BITS-1:0] prio;
  logic                     attached;

  // a ranks after b: invalid last, then larger priority, then larger index
  function automatic logic ranks_after(
    input logic                     av,
    input logic [PRIORITY_BITS-1:0] ap,
    input logic [IDX_W-1:0]         ai,
    input logic                     bv,
    input logic [PRIORITY_BITS-1:0] bp,
    input logic [IDX_W-1:0]         bi
  );
    return (!av && bv) ||
           (av && bv && ((ap > bp) || ((ap == bp) && (ai > bi))));
  endfunction

  logic hit;
  logic is_left;
  logic is_right;
  logic take_right;
  logic take_left;

  assign hit      = ctrl.table_wr && (int'(ctrl.source) == IDX);
  assign is_left  = HAS_RIGHT && (ODD == ctrl.phase);
  assign is_right = HAS_LEFT && (ODD != ctrl.phase);
  assign take_right = is_left &&
    ranks_after(slot_valid, slot_prio, slot_idx, right_valid, right_prio, right_idx);
  assign take_left = is_right &&
    ranks_after(left_valid, left_prio, left_idx, slot_valid, slot_prio, slot_idx);

  // table entry
  always_ff @(posedge clk) begin
    if (rst) begin
      prio     <= RST_PRIO;
      attached <= 1'b0;
    end else if (hit) begin
      case (ctrl.kind)
        pid_pkg::KIND_ATTACH: begin
          prio     <= new_prio;
          attached <= 1'b1;
        end
        pid_pkg::KIND_DETACH: begin
          prio     <= dflt_prio;
          attached <= 1'b0;
        end
        pid_pkg::KIND_SET_PRIO: begin
          prio <= new_prio;
        end
        default: begin
        end
      endcase
    end
  end

  // sort slot
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (ctrl.load) begin
      slot_valid <= pend;
    end else if (ctrl.sort && take_right) begin
      slot_valid <= right_valid;
    end else if (ctrl.sort && take_left) begin
      slot_valid <= left_valid;
    end else if (ctrl.shift) begin
      slot_valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot_prio <= prio;
      slot_idx  <= IDX_W'(IDX);
      slot_att  <= attached;
    end else if ((ctrl.sort && take_right) || ctrl.shift) begin
      slot_prio <= right_prio;
      slot_idx  <= right_idx;
      slot_att  <= right_att;
    end else if (ctrl.sort && take_left) begin
      slot_prio <= left_prio;
      slot_idx  <= left_idx;
      slot_att  <= left_att;
    end
  end

endmodule

// ===== hw/rtl/pid_seq.sv =====
// ---------------------------------------------------------------------------
// pid_seq: request sequencer
// Takes requests, runs the sort steps of a dispatch and paces the results.
// ---------------------------------------------------------------------------
module pid_seq #(
  parameter int NUM_SOURCES = pid_pkg::NUM_SOURCES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pid_pkg::KIND_W-1:0]   in_kind,
  input  logic [pid_pkg::SRC_W-1:0]    in_source,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         head_valid,
  input  logic                         head_last,
  output pid_pkg::cell_ctrl_t          ctrl
);

  localparam int CNT_W = $clog2(NUM_SOURCES);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_SOURCES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             out_fire;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_OUT) && head_valid;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    ctrl          = '0;
    ctrl.kind     = in_kind;
    ctrl.source   = in_source;
    ctrl.table_wr = accept && (in_kind != pid_pkg::KIND_DISPATCH);
    ctrl.load     = accept && (in_kind == pid_pkg::KIND_DISPATCH);
    ctrl.sort     = (state == ST_SORT);
    ctrl.phase    = cnt[0];
    ctrl.shift    = out_fire;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_kind == pid_pkg::KIND_DISPATCH)) state_next = ST_SORT;
      end
      ST_SORT: begin
        if (cnt == CNT_END) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!head_valid || (out_fire && head_last)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SORT) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/priority_interrupt_dispatcher.sv =====
// ---------------------------------------------------------------------------
// priority_interrupt_dispatcher: per-source priority table and dispatcher
// Request stream on s_*, result stream on m_*, one config register on cfg_*.
// A request is taken when s_tvalid and s_tready are high at a clock edge.
// s_tuser carries the kind: attach, detach, set priority or dispatch.
// Table requests finish in the cycle they are taken and give no result.
// A dispatch copies the table and its pending mask into a row of cells,
// sorts them with NUM_SOURCES odd-even exchange steps (one per cycle),
// then emits one served source per cycle while m_tready is high, best first;
// m_tlast marks the final one. s_tready stays low for the whole dispatch:
// one request is in work at a time. A low m_tready simply holds the current
// result; nothing is lost.
// rst (synchronous) clears every attached flag, sets all priorities to
// 128 and the default priority register to 128.
// cfg_wr_data is taken into default_priority whenever cfg_wr_en is high and rst is low.
// ---------------------------------------------------------------------------
module priority_interrupt_dispatcher #(
  parameter int NUM_SOURCES   = pid_pkg::NUM_SOURCES_DEF,
  parameter int PRIORITY_BITS = pid_pkg::PRIORITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // default_priority
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,       // source[4:0], new_priority[12:5], pending_mask[44:13]
  input  logic [1:0]  s_tuser,       // kind[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // served_source[4:0]
  output logic        m_tuser,       // has_handler
  output logic        m_tlast        // last
);

  localparam int IDX_W = $clog2(NUM_SOURCES);
  localparam int PW    = pid_pkg::PRIO_MAX_W;

  // request fields
  logic [pid_pkg::SRC_W-1:0]     req_source;
  logic [pid_pkg::PRIO_IN_W-1:0] req_prio;
  logic [pid_pkg::MASK_W-1:0]    req_mask;

  assign req_source = s_tdata[4:0];
  assign req_prio   = s_tdata[12:5];
  assign req_mask   = s_tdata[44:13];

  // default priority register
  logic [pid_pkg::PRIO_IN_W-1:0] default_priority;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_priority <= pid_pkg::DEFAULT_PRIO_RESET;
    end else if (cfg_wr_en) begin
      default_priority <= cfg_wr_data;
    end
  end

  // only the low PRIORITY_BITS of a priority are kept
  logic [PW-1:0]            new_wide;
  logic [PW-1:0]            dflt_wide;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [PRIORITY_BITS-1:0] dflt_prio;

  assign new_wide  = PW'(req_prio);
  assign dflt_wide = PW'(default_priority);
  assign new_prio  = new_wide[PRIORITY_BITS-1:0];
  assign dflt_prio = dflt_wide[PRIORITY_BITS-1:0];

  // sequencer
  pid_pkg::cell_ctrl_t ctrl;
  logic                head_valid;
  logic                head_last;

  pid_seq #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_source (req_source),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head_valid(head_valid),
    .head_last (head_last),
    .ctrl      (ctrl)
  );

  // row of cells; slot 0 is the head of the sorted order
  logic                     slot_valid [NUM_SOURCES];
  logic [PRIORITY_BITS-1:0] slot_prio  [NUM_SOURCES];
  logic [IDX_W-1:0]         slot_idx   [NUM_SOURCES];
  logic                     slot_att   [NUM_SOURCES];

  for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_cell
    logic                     pend;
    logic                     lv;
    logic [PRIORITY_BITS-1:0] lp;
    logic [IDX_W-1:0]         li;
    logic                     la;
    logic                     rv;
    logic [PRIORITY_BITS-1:0] rp;
    logic [IDX_W-1:0]         ri;
    logic                     ra;

    // pending bits beyond the 32-bit mask never exist
    if (i < pid_pkg::MASK_W) begin : g_pend
      assign pend = req_mask[i];
    end else begin : g_nopend
      assign pend = 1'b0;
    end

    if (i > 0) begin : g_left
      assign lv = slot_valid[i-1];
      assign lp = slot_prio[i-1];
      assign li = slot_idx[i-1];
      assign la = slot_att[i-1];
    end else begin : g_noleft
      assign lv = 1'b0;
      assign lp = '0;
      assign li = '0;
      assign la = 1'b0;
    end

    // the end of the row shifts in an empty slot
    if (i < NUM_SOURCES - 1) begin : g_right
      assign rv = slot_valid[i+1];
      assign rp = slot_prio[i+1];
      assign ri = slot_idx[i+1];
      assign ra = slot_att[i+1];
    end else begin : g_noright
      assign rv = 1'b0;
      assign rp = '0;
      assign ri = '0;
      assign ra = 1'b0;
    end

    pid_cell #(
      .NUM_SOURCES  (NUM_SOURCES),
      .PRIORITY_BITS(PRIORITY_BITS),
      .IDX          (i),
      .IDX_W        (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_prio   (new_prio),
      .dflt_prio  (dflt_prio),
      .pend       (pend),
      .left_valid (lv),
      .left_prio  (lp),
      .left_idx   (li),
      .left_att   (la),
      .right_valid(rv),
      .right_prio (rp),
      .right_idx  (ri),
      .right_att  (ra),
      .slot_valid (slot_valid[i]),
      .slot_prio  (slot_prio[i]),
      .slot_idx   (slot_idx[i]),
      .slot_att   (slot_att[i])
    );
  end

  // head of the row drives the result stream
  assign head_valid = slot_valid[0];
  assign head_last  = !slot_valid[1];

  logic [pid_pkg::SRC_W-1:0] served_source;
  assign served_source = pid_pkg::SRC_W'(slot_idx[0]);

  assign m_tdata = {3'b000, served_source};
  assign m_tuser = slot_att[0];
  assign m_tlast = head_last;

endmodule

// ===== bench/dispatch_order_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dispatch_order_checker: predicts and checks the dispatcher's result stream
// Shadows the source table and the default priority, turns every accepted
// dispatch request into its expected served sources and compares each
// result on the m_* channel against the oldest one still waiting.
// ---------------------------------------------------------------------------
module dispatch_order_checker #(
  parameter int SOURCES = pid_pkg::NUM_SOURCES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          error_count,
  output int          pending_results
);

  typedef struct {
    logic [pid_pkg::SRC_W-1:0] source;
    logic                      has_handler;
    logic                      last;
  } served_t;

  logic [pid_pkg::PRIO_IN_W-1:0] prio_table [SOURCES];
  logic                          attached_table [SOURCES];
  logic [pid_pkg::PRIO_IN_W-1:0] default_prio;
  served_t                       served_queue [$];
  int                            errors = 0;

  // Serve order of one snapshot: lowest priority value first, lower index on ties.
  function automatic void queue_dispatch_order(input logic [pid_pkg::MASK_W-1:0] mask);
    logic [pid_pkg::MASK_W-1:0] left;
    int                         pick;
    served_t                    item;
    left = mask;
    // bits beyond the last source are dropped
    for (int i = SOURCES; i < pid_pkg::MASK_W; i++)
      left[i] = 1'b0;
    while (left != '0) begin
      pick = -1;
      for (int i = 0; i < SOURCES; i++)
        if (left[i] && (pick < 0 || prio_table[i] < prio_table[pick]))
          pick = i;
      left[pick]       = 1'b0;
      item.source      = pick[pid_pkg::SRC_W-1:0];
      item.has_handler = attached_table[pick];
      item.last        = (left == '0);
      served_queue.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    logic [pid_pkg::KIND_W-1:0]    kind;
    logic [pid_pkg::SRC_W-1:0]     src;
    logic [pid_pkg::PRIO_IN_W-1:0] prio;
    logic [pid_pkg::MASK_W-1:0]    mask;
    served_t                       want;
    if (rst) begin
      default_prio = pid_pkg::DEFAULT_PRIO_RESET;
      for (int i = 0; i < SOURCES; i++) begin
        prio_table[i]     = pid_pkg::DEFAULT_PRIO_RESET;
        attached_table[i] = 1'b0;
      end
      served_queue.delete();
    end else begin
      if (cfg_wr_en)
        default_prio = cfg_wr_data;

      if (s_tvalid && s_tready) begin
        kind = s_tuser;
        src  = s_tdata[4:0];
        prio = s_tdata[12:5];
        mask = s_tdata[44:13];
        case (kind)
          pid_pkg::KIND_ATTACH: begin
            prio_table[src]     = prio;
            attached_table[src] = 1'b1;
          end
          pid_pkg::KIND_DETACH: begin
            prio_table[src]     = default_prio;
            attached_table[src] = 1'b0;
          end
          pid_pkg::KIND_SET_PRIO: prio_table[src] = prio;
          pid_pkg::KIND_DISPATCH: queue_dispatch_order(mask);
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        if (served_queue.size() == 0) begin
          $error("unexpected result: served_source %0d", m_tdata[4:0]);
          errors++;
        end else begin
          want = served_queue.pop_front();
          if (m_tdata[4:0] !== want.source) begin
            $error("served_source: expected %0d, got %0d", want.source, m_tdata[4:0]);
            errors++;
          end
          if (m_tuser !== want.has_handler) begin
            $error("has_handler: expected %0b, got %0b", want.has_handler, m_tuser);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
    end
    // nonblocking so the stimulus side sees a stable value after the edge
    error_count     <= errors;
    pending_results <= served_queue.size();
  end

endmodule

// ===== bench/priority_interrupt_dispatcher_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_interrupt_dispatcher_test: stimulus and verdict for the dispatcher
// Drives table and dispatch requests with random sender gaps and receiver
// stalls, changes the default priority between phases, and leaves all
// prediction and checking to dispatch_order_checker.
// ---------------------------------------------------------------------------
module priority_interrupt_dispatcher_test;

  localparam int SOURCES = pid_pkg::NUM_SOURCES_DEF;
  // an empty dispatch keeps the block busy with no result to wait for
  localparam int SETTLE_CYCLES = SOURCES + 8;
  // run limit in ns with a 2 ns clock, far beyond the slowest correct run
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // source[4:0], new_priority[12:5], pending_mask[44:13]
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // served_source[4:0]
  logic        m_tuser;        // has_handler
  logic        m_tlast;        // last

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count;
  int pending_results;

  always #1 clk = ~clk;

  priority_interrupt_dispatcher u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  dispatch_order_checker #(.SOURCES(SOURCES)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .error_count    (error_count),
    .pending_results(pending_results)
  );

  // Receiver stalls: drop ready in recv_idle_pct of the cycles.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One request. tvalid stays high into the next request unless a gap
  // is taken, so it is never dropped and raised in the same step.
  task automatic send_request(input logic [pid_pkg::KIND_W-1:0] kind,
                              input logic [pid_pkg::SRC_W-1:0] src,
                              input logic [pid_pkg::PRIO_IN_W-1:0] prio,
                              input logic [pid_pkg::MASK_W-1:0] mask);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, mask, prio, src};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold off requests until every predicted result has come out and an
  // empty dispatch, if one was last, has had time to finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_default(input logic [7:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random traffic: table updates with tie-heavy priorities and dispatches
  // with dense, sparse, single-bit, full and empty snapshots.
  task automatic random_requests(input int count);
    logic [pid_pkg::KIND_W-1:0]    kind;
    logic [pid_pkg::PRIO_IN_W-1:0] prio;
    logic [pid_pkg::MASK_W-1:0]    mask;
    int                            pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30)      kind = pid_pkg::KIND_ATTACH;
      else if (pick < 45) kind = pid_pkg::KIND_DETACH;
      else if (pick < 65) kind = pid_pkg::KIND_SET_PRIO;
      else                kind = pid_pkg::KIND_DISPATCH;
      case ($urandom_range(3))
        0:       prio = pid_pkg::PRIO_IN_W'($urandom_range(3));   // many ties
        1:       prio = $urandom_range(1) ? 8'hFF : 8'h00;
        default: prio = pid_pkg::PRIO_IN_W'($urandom_range(255));
      endcase
      case ($urandom_range(5))
        0:       mask = $urandom();
        1:       mask = 32'h1 << $urandom_range(31);
        2:       mask = $urandom() & $urandom() & $urandom();
        3:       mask = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        default: mask = $urandom() | $urandom();
      endcase
      send_request(kind, pid_pkg::SRC_W'($urandom_range(31)), prio, mask);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 81;

    // After reset: all unhandled at the same priority, so index order.
    send_request(pid_pkg::KIND_DISPATCH, 5'd31, 8'hFF, 32'hFFFF_FFFF);
    // empty snapshot gives nothing
    send_request(pid_pkg::KIND_DISPATCH, 5'd0, 8'h00, 32'h0);
    // table requests carry junk in the mask
    send_request(pid_pkg::KIND_ATTACH, 5'd0, 8'hFF, 32'hFFFF_FFFF);
    send_request(pid_pkg::KIND_ATTACH, 5'd31, 8'h00, 32'hA5A5_5A5A);
    send_request(pid_pkg::KIND_ATTACH, 5'd5, 8'h00, $urandom());
    send_request(pid_pkg::KIND_SET_PRIO, 5'd7, 8'h00, $urandom());
    send_request(pid_pkg::KIND_SET_PRIO, 5'd9, 8'hFF, $urandom());
    send_request(pid_pkg::KIND_ATTACH, 5'd12, 8'd128, $urandom());
    // tie at priority 0 between 5, 7 and 31: lower index goes first
    send_request(pid_pkg::KIND_DISPATCH, pid_pkg::SRC_W'($urandom_range(31)),
                 pid_pkg::PRIO_IN_W'($urandom_range(255)), 32'hFFFF_FFFF);
    send_request(pid_pkg::KIND_DISPATCH, 5'd0, 8'h00, 32'h8000_0001);
    send_request(pid_pkg::KIND_DISPATCH, 5'd31, 8'hFF, 32'h8000_0000);
    // detach restores the default priority and clears the handler
    send_request(pid_pkg::KIND_DETACH, 5'd31, 8'h00, 32'hFFFF_FFFF);
    send_request(pid_pkg::KIND_DISPATCH, 5'd0, 8'h00, 32'h8000_00A1);

    write_default(8'h00);
    send_request(pid_pkg::KIND_DETACH, 5'd0, 8'hFF, $urandom());
    send_request(pid_pkg::KIND_DETACH, 5'd5, 8'hFF, $urandom());
    send_request(pid_pkg::KIND_DISPATCH, 5'd0, 8'h00, 32'h0000_0221);

    write_default(8'hFF);
    send_request(pid_pkg::KIND_DETACH, 5'd7, 8'h00, $urandom());
    send_request(pid_pkg::KIND_SET_PRIO, 5'd3, 8'hAA, $urandom());
    send_request(pid_pkg::KIND_DISPATCH, 5'd0, 8'h00, 32'h8000_1288);
    send_request(pid_pkg::KIND_DISPATCH, 5'd0, 8'h00, 32'hFFFF_FFFF);

    write_default(8'd128);
    random_requests(100);

    write_default(8'($urandom_range(255)));
    send_idle_pct = 81;
    recv_idle_pct = 32;
    random_requests(100);

    write_default(8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(100);

    drain();
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog for a hung handshake or lost results.
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
